// File: rtl/fpd_pkg.sv
// Shared constants and types for the fuzzy PD controller.
// No dependencies; used by fuzzy_pd_controller and fpd_div.
package fpd_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int REG_W          = 15;
    localparam int Q_SHIFT        = 16;
    localparam int MEM_W          = Q_SHIFT + 1;
    localparam int MIN_STRENGTH   = 6;

    localparam logic [REG_W-1:0] ERROR_RANGE_RST = 15'd8192;
    localparam logic [REG_W-1:0] RATE_RANGE_RST  = 15'd8192;
    localparam logic [REG_W-1:0] OUTPUT_MAX_RST  = 15'd16384;

    typedef enum logic [1:0] {
        CFG_ERROR_RANGE = 2'd0,
        CFG_RATE_RANGE  = 2'd1,
        CFG_OUTPUT_MAX  = 2'd2
    } t_cfg_idx;

endpackage

// File: rtl/fpd_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Uses fpd_pkg for its default quotient width; instantiated by fuzzy_pd_controller.
module fpd_div #(
    parameter int LANES = 1,
    parameter int NW    = 32,
    parameter int DW    = 16,
    parameter int QW    = fpd_pkg::MEM_W,
    parameter int SW    = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num [LANES],
    input  logic [DW-1:0] i_den [LANES],
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo [LANES],
    output logic [SW-1:0] o_side
);

    logic [QW:0]   r_vld;
    logic [NW-1:0] r_num  [0:QW][LANES];
    logic [DW-1:0] r_den  [0:QW][LANES];
    logic [DW-1:0] r_rem  [0:QW][LANES];
    logic [QW-1:0] r_q    [0:QW][LANES];
    logic [SW-1:0] r_side [0:QW];
    logic [DW-1:0] n_rem  [1:QW][LANES];
    logic [QW-1:0] n_q    [1:QW][LANES];

    always_comb begin
        logic [DW:0] t;
        logic        ge;
        for (int s = 1; s <= QW; s++) begin
            for (int l = 0; l < LANES; l++) begin
                t  = {r_rem[s-1][l], r_num[s-1][l][QW-s]};
                ge = (t >= {1'b0, r_den[s-1][l]});
                n_rem[s][l] = ge ? DW'(t - {1'b0, r_den[s-1][l]}) : DW'(t);
                n_q[s][l]   = r_q[s-1][l];
                n_q[s][l][QW-s] = ge;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int l = 0; l < LANES; l++) begin
                r_num[0][l] <= i_num[l];
                r_den[0][l] <= i_den[l];
                r_rem[0][l] <= DW'(i_num[l] >> QW);
                r_q[0][l]   <= '0;
            end
            for (int s = 1; s <= QW; s++) begin
                r_side[s] <= r_side[s-1];
                for (int l = 0; l < LANES; l++) begin
                    r_num[s][l] <= r_num[s-1][l];
                    r_den[s][l] <= r_den[s-1][l];
                    r_rem[s][l] <= n_rem[s][l];
                    r_q[s][l]   <= n_q[s][l];
                end
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_side  = r_side[QW];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_q[QW][l];
        end
    end

endmodule

// File: rtl/fuzzy_pd_controller.sv
// Top level of the fuzzy PD controller: fuzzification, rule evaluation,
// defuzzification. Depends on fpd_pkg and fpd_div.
//
// Usage: an error and an error rate enter as one transfer on the s_axis
// channel (tdata holds error_in in the low bits, error_rate_in above it).
// Each transfer yields one result on the m_axis channel: tdata holds
// drive_out, tuser holds no_rule_fired. The three range registers are
// written on the cfg channel, which is always ready; write them only while
// no item is in flight.
// The input transfer passes through 40 register stages to the result.
// A new item is accepted every cycle unless the receiver stalls; most stages
// lie in the two divider pipelines (18 stages for the memberships, 17 for the average).
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the default ranges
// (8192, 8192, 16384).
module fuzzy_pd_controller #(
    parameter int DATA_WIDTH = fpd_pkg::DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: error_in, error_rate_in, zero padding.
    input  logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: drive_out, zero padding.
    output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // Fields from bit 0: no_rule_fired.
    output logic                   m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [fpd_pkg::REG_W-1:0] i_cfg_data
);

    localparam int IN_BYTES  = (2 * DATA_WIDTH + 7) / 8;
    localparam int OUT_BYTES = (DATA_WIDTH + 7) / 8;
    localparam int RW   = fpd_pkg::REG_W;
    localparam int QS   = fpd_pkg::Q_SHIFT;
    localparam int MW   = fpd_pkg::MEM_W;
    localparam int XW   = ((DATA_WIDTH > 16) ? DATA_WIDTH : 16) + 2;
    localparam int PW   = RW + 2;
    localparam int SUMW = MW + 2;
    localparam int SWW  = MW + 4;
    localparam int PRW  = SWW + RW + 1;
    localparam int MAGW = PRW - 1;
    localparam int QDW  = SUMW + 1;
    localparam int QOW  = RW + 1;
    localparam logic [31:0] LIM = 32'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);

    logic [RW-1:0] r_err_range, r_rate_range, r_omax;
    logic          en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_range  <= fpd_pkg::ERROR_RANGE_RST;
            r_rate_range <= fpd_pkg::RATE_RANGE_RST;
            r_omax       <= fpd_pkg::OUTPUT_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fpd_pkg::CFG_ERROR_RANGE: r_err_range  <= i_cfg_data;
                fpd_pkg::CFG_RATE_RANGE:  r_rate_range <= i_cfg_data;
                fpd_pkg::CFG_OUTPUT_MAX:  r_omax       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Position 2x + 2r of the clamped input, in [0, 4r].
    function automatic logic [PW-1:0] fuzz_pos(input logic signed [DATA_WIDTH-1:0] x,
                                               input logic [RW-1:0] r);
        logic signed [XW-1:0] xs, rs, xc;
        xs = XW'(x);
        rs = $signed({{(XW-RW){1'b0}}, r});
        xc = xs;
        if (xs > rs)  xc = rs;
        if (xs < -rs) xc = -rs;
        return PW'((xc <<< 1) + (rs <<< 1));
    endfunction

    // Segment s with s*r <= p < (s+1)*r (s = 3 at p = 4r) and offset p - s*r.
    function automatic logic [RW+1:0] fuzz_seg(input logic [PW-1:0] p,
                                               input logic [RW-1:0] r);
        logic [PW-1:0] r1, r2, r3;
        logic [1:0]    s;
        logic [PW-1:0] base;
        r1 = PW'(r);
        r2 = PW'({r, 1'b0});
        r3 = r1 + r2;
        if (p >= r3) begin
            s = 2'd3;
            base = r3;
        end else if (p >= r2) begin
            s = 2'd2;
            base = r2;
        end else if (p >= r1) begin
            s = 2'd1;
            base = r1;
        end else begin
            s = 2'd0;
            base = '0;
        end
        return {s, RW'(p - base)};
    endfunction

    // Stage A: input register.
    logic                         r_a_vld;
    logic signed [DATA_WIDTH-1:0] r_a_err, r_a_rate;
    // Stage B: clamped positions.
    logic                         r_b_vld;
    logic [PW-1:0]                r_b_pe, r_b_pr;
    logic [RW-1:0]                r_b_re, r_b_rr;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= s_axis_tvalid;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_err  <= s_axis_tdata[DATA_WIDTH-1:0];
            r_a_rate <= s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
            r_b_re   <= (r_err_range == '0) ? RW'(1) : r_err_range;
            r_b_rr   <= (r_rate_range == '0) ? RW'(1) : r_rate_range;
            r_b_pe   <= fuzz_pos(r_a_err, (r_err_range == '0) ? RW'(1) : r_err_range);
            r_b_pr   <= fuzz_pos(r_a_rate, (r_rate_range == '0) ? RW'(1) : r_rate_range);
        end
    end

    logic [RW+1:0]         seg_e, seg_r;
    logic [RW-1:0]         a_e, a_r, ca_e, ca_r;
    logic [RW+QS-1:0]      d1_num [4];
    logic [RW-1:0]         d1_den [4];
    logic                  d1_vld;
    logic [MW-1:0]         d1_quo [4];
    logic [3:0]            d1_side;

    assign seg_e = fuzz_seg(r_b_pe, r_b_re);
    assign seg_r = fuzz_seg(r_b_pr, r_b_rr);
    assign a_e   = seg_e[RW-1:0];
    assign a_r   = seg_r[RW-1:0];
    assign ca_e  = r_b_re - a_e;
    assign ca_r  = r_b_rr - a_r;

    always_comb begin
        d1_num[0] = {ca_e, QS'(0)};
        d1_num[1] = {a_e,  QS'(0)};
        d1_num[2] = {ca_r, QS'(0)};
        d1_num[3] = {a_r,  QS'(0)};
        d1_den[0] = r_b_re;
        d1_den[1] = r_b_re;
        d1_den[2] = r_b_rr;
        d1_den[3] = r_b_rr;
    end

    fpd_div #(
        .LANES(4),
        .NW   (RW + QS),
        .DW   (RW),
        .QW   (MW),
        .SW   (4)
    ) u_mem_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_b_vld),
        .i_num  (d1_num),
        .i_den  (d1_den),
        .i_side ({seg_r[RW+1:RW], seg_e[RW+1:RW]}),
        .o_valid(d1_vld),
        .o_quo  (d1_quo),
        .o_side (d1_side)
    );

    // Stage D: the four rules that can fire, strength sum and weighted sum.
    logic                   r_d_vld;
    logic signed [SWW-1:0]  r_d_sw;
    logic [SUMW-1:0]        r_d_den;
    logic signed [SWW-1:0]  n_d_sw;
    logic [SUMW-1:0]        n_d_den;

    always_comb begin
        logic [MW-1:0]        s;
        logic signed [3:0]    w;
        logic signed [SWW-1:0] t;
        n_d_sw  = '0;
        n_d_den = '0;
        for (int ea = 0; ea < 2; ea++) begin
            for (int rb = 0; rb < 2; rb++) begin
                s = (d1_quo[ea] < d1_quo[2 + rb]) ? d1_quo[ea] : d1_quo[2 + rb];
                w = $signed({2'b00, d1_side[1:0]}) + $signed({2'b00, d1_side[3:2]})
                    + 4'(ea + rb) - 4'sd4;
                t = $signed({{(SWW-MW){1'b0}}, s});
                n_d_den = n_d_den + SUMW'(s);
                if (w >= 4'sd2)       n_d_sw = n_d_sw + (t <<< 1);
                else if (w == 4'sd1)  n_d_sw = n_d_sw + t;
                else if (w == -4'sd1) n_d_sw = n_d_sw - t;
                else if (w <= -4'sd2) n_d_sw = n_d_sw - (t <<< 1);
            end
        end
    end

    // Stage E: scale by output_max.
    logic                  r_e_vld;
    logic signed [PRW-1:0] r_e_num;
    logic [SUMW-1:0]       r_e_den;
    logic signed [PRW-1:0] e_prod;

    assign e_prod = r_d_sw * $signed({1'b0, r_omax});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= d1_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sw  <= n_d_sw;
            r_d_den <= n_d_den;
            r_e_num <= e_prod;
            r_e_den <= r_d_den;
        end
    end

    logic [MAGW-1:0] e_mag;
    logic            e_neg, e_weak;
    logic [MAGW-1:0] d2_num [1];
    logic [QDW-1:0]  d2_den [1];
    logic            d2_vld;
    logic [QOW-1:0]  d2_quo [1];
    logic [1:0]      d2_side;

    assign e_neg  = r_e_num[PRW-1];
    assign e_mag  = e_neg ? MAGW'(-r_e_num) : MAGW'(r_e_num);
    assign e_weak = (r_e_den <= SUMW'(fpd_pkg::MIN_STRENGTH));

    always_comb begin
        d2_num[0] = e_mag;
        d2_den[0] = {r_e_den, 1'b0};
    end

    fpd_div #(
        .LANES(1),
        .NW   (MAGW),
        .DW   (QDW),
        .QW   (QOW),
        .SW   (2)
    ) u_avg_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_e_vld),
        .i_num  (d2_num),
        .i_den  (d2_den),
        .i_side ({e_weak, e_neg}),
        .o_valid(d2_vld),
        .o_quo  (d2_quo),
        .o_side (d2_side)
    );

    // Output register.
    logic                  r_o_vld;
    logic [DATA_WIDTH-1:0] r_o_drive;
    logic                  r_o_flag;
    logic [QOW-1:0]        q_om;
    logic [31:0]           q_lim;
    logic [DATA_WIDTH-1:0] n_drive;

    always_comb begin
        q_om  = (d2_quo[0] > QOW'(r_omax)) ? QOW'(r_omax) : d2_quo[0];
        q_lim = (32'(q_om) > LIM) ? LIM : 32'(q_om);
        if (d2_side[1]) begin
            n_drive = '0;
        end else if (d2_side[0]) begin
            n_drive = DATA_WIDTH'(-q_lim);
        end else begin
            n_drive = DATA_WIDTH'(q_lim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_drive <= n_drive;
            r_o_flag  <= d2_side[1];
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = (OUT_BYTES*8)'(r_o_drive);
    assign m_axis_tuser  = r_o_flag;

endmodule
